// ===== design/gbfs_pkg.sv =====
package gbfs_pkg;

  // default grid edge length of the cell array
  localparam int GBFS_MAX_DIM = 32;

  // widths fixed by the request fields
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int DIST_W  = 10;

  // request commands
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

  // control broadcast from the sequencer to every row cell
  typedef struct packed {
    logic               clear;    // drop all obstacles
    logic               mark;     // set obstacle at sel_row / sel_col
    logic               load;     // seed the wavefront at sel_row / sel_col
    logic               advance;  // grow the wavefront by one step
    logic [COORD_W-1:0] sel_row;
    logic [COORD_W-1:0] sel_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
    logic [COORD_W-1:0] grid_h;
    logic [COORD_W-1:0] grid_w;
  } gbfs_ctrl_t;

endpackage

// ===== design/gbfs_row_cell.sv =====
module gbfs_row_cell #(
  parameter int MAX_DIM = gbfs_pkg::GBFS_MAX_DIM,
  parameter int ROW     = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbfs_pkg::gbfs_ctrl_t ctrl_i,
  input  logic [MAX_DIM-1:0]  reach_prev_i,
  input  logic [MAX_DIM-1:0]  reach_next_i,
  output logic [MAX_DIM-1:0]  reach_o,
  output logic                hit_o
);
  import gbfs_pkg::*;

  localparam int CMP_W = COORD_W + 1;
  localparam logic [CMP_W-1:0] ROW_NUM = CMP_W'(ROW + 1);

  logic [MAX_DIM-1:0] blk_q, blk_d;
  logic [MAX_DIM-1:0] reach_q, reach_d;
  logic [MAX_DIM-1:0] sel_col_oh, end_col_oh, col_en, nbr;
  logic               row_sel, row_end, row_en;

  // one-based column decode, values off the map match nothing
  always_comb begin
    for (int j = 0; j < MAX_DIM; j++) begin
      sel_col_oh[j] = ({1'b0, ctrl_i.sel_col} == CMP_W'(j + 1));
      end_col_oh[j] = ({1'b0, ctrl_i.end_col} == CMP_W'(j + 1));
      col_en[j]     = ({1'b0, ctrl_i.grid_w} >= CMP_W'(j + 1));
    end
  end

  assign row_sel = ({1'b0, ctrl_i.sel_row} == ROW_NUM);
  assign row_end = ({1'b0, ctrl_i.end_row} == ROW_NUM);
  assign row_en  = ({1'b0, ctrl_i.grid_h} >= ROW_NUM);

  // reached cells above, below, left and right
  assign nbr = reach_prev_i | reach_next_i | (reach_q << 1) | (reach_q >> 1);

  always_comb begin
    blk_d = blk_q;
    if (ctrl_i.clear) begin
      blk_d = '0;
    end else if (ctrl_i.mark && row_sel) begin
      blk_d = blk_q | sel_col_oh;
    end
  end

  always_comb begin
    reach_d = reach_q;
    if (ctrl_i.load) begin
      reach_d = row_sel ? sel_col_oh : '0;
    end else if (ctrl_i.advance) begin
      reach_d = reach_q | (nbr & col_en & ~blk_q & {MAX_DIM{row_en}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q   <= '0;
      reach_q <= '0;
    end else begin
      blk_q   <= blk_d;
      reach_q <= reach_d;
    end
  end

  assign reach_o = reach_q;
  assign hit_o   = row_end & (|(reach_q & ~blk_q & end_col_oh));

endmodule

// ===== design/grid_bfs_step_limited_reach.sv =====
// Step-limited shortest-path search on a 4-connected grid of up to MAX_DIM x MAX_DIM
// cells. A begin request drops all obstacles and latches grid size, start, target and
// step limit; block requests mark obstacle cells (cells off the map are ignored); a run
// request returns one result: reachable plus the shortest distance when the target is
// reached within the step limit and is not an obstacle, else not reachable with
// distance 0. The search is a wavefront over a chain of MAX_DIM row cells: each row
// holds its obstacle and reached bits and trades its reached vector with the rows above
// and below every cycle, so the front grows one step per cycle. A run ends when the
// target joins the front or once the front stands at the step limit. No request is
// taken while a run is in flight, and a finished run waits for the result register
// to free.
module grid_bfs_step_limited_reach #(
  parameter int MAX_DIM = gbfs_pkg::GBFS_MAX_DIM
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gbfs_pkg::CMD_W-1:0]    command_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  grid_height_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  grid_width_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  start_row_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  start_col_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  end_row_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  end_col_i,
  input  logic [gbfs_pkg::DIST_W-1:0]   step_limit_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  cell_row_i,
  input  logic [gbfs_pkg::COORD_W-1:0]  cell_col_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          reachable_o,
  output logic [gbfs_pkg::DIST_W-1:0]   distance_o
);
  import gbfs_pkg::*;

  // sequencer states
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state_q, state_d;

  // latched query header
  logic [COORD_W-1:0] hdr_h_q, hdr_w_q, hdr_srow_q, hdr_scol_q, hdr_erow_q, hdr_ecol_q;
  logic [DIST_W-1:0]  limit_q;

  // current wavefront step
  logic [DIST_W-1:0]  step_q, step_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic               reachable_q;
  logic [DIST_W-1:0]  distance_q;

  logic               in_acc, out_free, hit, done, finish;
  gbfs_ctrl_t         ctrl;

  logic [MAX_DIM-1:0] hit_vec;
  // row vectors with an all-zero row above the first and below the last
  logic [MAX_DIM-1:0] reach_pad [MAX_DIM+2];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // target reached by the front, and not an obstacle
  assign hit  = |hit_vec;
  // stop at the target or once the front stands at the step limit
  assign done = hit || (step_q == limit_q);
  // a finished run leaves only when the result register can take it
  assign finish = (state_q == ST_SEARCH) && done && out_free;

  // broadcast to the row cells
  always_comb begin
    ctrl.clear   = in_acc && (command_i == CMD_BEGIN);
    ctrl.mark    = in_acc && (command_i == CMD_BLOCK);
    ctrl.load    = in_acc && (command_i == CMD_RUN);
    ctrl.advance = (state_q == ST_SEARCH) && !done;
    // obstacle address for block requests, seed cell for run requests
    ctrl.sel_row = (command_i == CMD_BLOCK) ? cell_row_i : hdr_srow_q;
    ctrl.sel_col = (command_i == CMD_BLOCK) ? cell_col_i : hdr_scol_q;
    ctrl.end_row = hdr_erow_q;
    ctrl.end_col = hdr_ecol_q;
    ctrl.grid_h  = hdr_h_q;
    ctrl.grid_w  = hdr_w_q;
  end

  // chain of row cells, each trades its reached row with both neighbors
  assign reach_pad[0]         = '0;
  assign reach_pad[MAX_DIM+1] = '0;

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_row
    gbfs_row_cell #(
      .MAX_DIM (MAX_DIM),
      .ROW     (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .reach_prev_i (reach_pad[i]),
      .reach_next_i (reach_pad[i+2]),
      .reach_o      (reach_pad[i+1]),
      .hit_o        (hit_vec[i])
    );
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (ctrl.load) begin
          state_d = ST_SEARCH;
          step_d  = '0;
        end
      end
      ST_SEARCH: begin
        if (finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else if (!done) begin
          step_d = step_q + DIST_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      hdr_h_q     <= '0;
      hdr_w_q     <= '0;
      hdr_srow_q  <= '0;
      hdr_scol_q  <= '0;
      hdr_erow_q  <= '0;
      hdr_ecol_q  <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (ctrl.clear) begin
        hdr_h_q    <= grid_height_i;
        hdr_w_q    <= grid_width_i;
        hdr_srow_q <= start_row_i;
        hdr_scol_q <= start_col_i;
        hdr_erow_q <= end_row_i;
        hdr_ecol_q <= end_col_i;
        limit_q    <= step_limit_i;
      end
    end
  end

  // result payload, distance is the step at which the target joined the front
  always_ff @(posedge clk_i) begin
    if (finish) begin
      reachable_q <= hit;
      distance_q  <= hit ? step_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reachable_o = reachable_q;
  assign distance_o  = distance_q;

  // the front never runs past the step limit
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (step_q <= limit_q))
    else $error("wavefront step beyond step limit");

  // a run request starts a search at step zero
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == CMD_RUN)) |=> ((state_q == ST_SEARCH) && (step_q == '0)))
    else $error("run request did not start a search");

  // the step counter moves by at most one per cycle
  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SEARCH) && $past(state_q == ST_SEARCH)) |->
      ((step_q == $past(step_q)) || (step_q == $past(step_q) + DIST_W'(1))))
    else $error("step counter jumped");

  // a search that is not done keeps going
  a_search_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SEARCH) && !done) |=> (state_q == ST_SEARCH))
    else $error("search left early");

  // a new result appears only at the end of a search
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SEARCH))
    else $error("result without a search");

endmodule

// ===== dv/tb_grid_bfs_step_limited_reach.sv =====
`timescale 1ns / 100ps

module tb_grid_bfs_step_limited_reach;
  import gbfs_pkg::*;

  localparam int DIM   = GBFS_MAX_DIM;
  localparam int CELLS = DIM * DIM;

  // the one command code the block has to ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // the watchdog limit leaves room for the longest run plus the long receiver hold-off
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int RANDOM_ITEMS   = 215;
  localparam int QUIET_ITEMS    = 20;
  localparam int LONG_HOLD      = 300;

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] grid_height, grid_width;
    logic [COORD_W-1:0] start_row, start_col, end_row, end_col;
    logic [DIST_W-1:0]  step_limit;
    logic [COORD_W-1:0] cell_row, cell_col;
  } grid_request_t;

  typedef struct {
    logic              reachable;
    logic [DIST_W-1:0] distance;
  } reach_answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i;
  logic [COORD_W-1:0] grid_height_i, grid_width_i;
  logic [COORD_W-1:0] start_row_i, start_col_i, end_row_i, end_col_i;
  logic [DIST_W-1:0]  step_limit_i;
  logic [COORD_W-1:0] cell_row_i, cell_col_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               reachable_o;
  logic [DIST_W-1:0]  distance_o;

  // 20 ns period
  always #10 clk_i = ~clk_i;

  grid_bfs_step_limited_reach #(
    .MAX_DIM(DIM)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .grid_height_i(grid_height_i),
    .grid_width_i (grid_width_i),
    .start_row_i  (start_row_i),
    .start_col_i  (start_col_i),
    .end_row_i    (end_row_i),
    .end_col_i    (end_col_i),
    .step_limit_i (step_limit_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reachable_o  (reachable_o),
    .distance_o   (distance_o)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the block state: latched query header and obstacle map
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] hdr_height = '0, hdr_width = '0;
  logic [COORD_W-1:0] hdr_srow = '0, hdr_scol = '0, hdr_erow = '0, hdr_ecol = '0;
  logic [DIST_W-1:0]  hdr_limit = '0;
  bit                 obstacle_map [CELLS];

  // answers still owed by the block, oldest first
  reach_answer_t expected_answers [$];

  // run bookkeeping
  int error_count     = 0;
  int requests_taken  = 0;
  int searches_taken  = 0;
  int ignored_taken   = 0;
  int reached_seen    = 0;
  int unreached_seen  = 0;
  int stuck_cycles    = 0;

  // knobs shared by the stimulus and the result sink
  bit idle_on      = 1'b1;
  int hold_request = 0;

  function automatic bit on_map(int r, int c);
    return r >= 1 && r <= DIM && c >= 1 && c <= DIM;
  endfunction

  function automatic int cell_of(int r, int c);
    return (r - 1) * DIM + (c - 1);
  endfunction

  // breadth-first wavefront from the start cell, cut off at the step limit
  function automatic reach_answer_t search_target();
    bit            reached [CELLS];
    int            depth [CELLS];
    int            wave [CELLS];
    int            head, tail, h, w, cur, r, c, nr, nc, n, k;
    reach_answer_t ans;
    ans.reachable = 1'b0;
    ans.distance  = '0;
    // grid size saturates to the map size
    h = (hdr_height > DIM) ? DIM : int'(hdr_height);
    w = (hdr_width > DIM) ? DIM : int'(hdr_width);
    head = 0;
    tail = 0;
    // a start off the map leaves the wavefront empty; a blocked start still seeds it
    if (on_map(hdr_srow, hdr_scol)) begin
      n          = cell_of(hdr_srow, hdr_scol);
      reached[n] = 1'b1;
      depth[n]   = 0;
      wave[tail] = n;
      tail++;
    end
    while (head < tail) begin
      cur = wave[head];
      head++;
      if (depth[cur] >= int'(hdr_limit)) break;
      r = cur / DIM + 1;
      c = cur % DIM + 1;
      // neighbor order: row+1, row-1, col+1, col-1
      for (k = 0; k < 4; k++) begin
        nr = r + ((k == 0) ? 1 : (k == 1) ? -1 : 0);
        nc = c + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
        // only cells inside the grid are entered, even from a start outside it
        if (nr < 1 || nr > h || nc < 1 || nc > w) continue;
        n = cell_of(nr, nc);
        if (reached[n] || obstacle_map[n]) continue;
        reached[n] = 1'b1;
        depth[n]   = depth[cur] + 1;
        wave[tail] = n;
        tail++;
      end
    end
    // target must be on the map, reached and not an obstacle
    if (on_map(hdr_erow, hdr_ecol)) begin
      n = cell_of(hdr_erow, hdr_ecol);
      if (reached[n] && !obstacle_map[n]) begin
        ans.reachable = 1'b1;
        ans.distance  = DIST_W'(depth[n]);
      end
    end
    return ans;
  endfunction

  // advance the shadow state by one accepted request
  function automatic void apply_request(grid_request_t q);
    case (q.command)
      CMD_BEGIN: begin
        obstacle_map = '{default: 1'b0};
        hdr_height   = q.grid_height;
        hdr_width    = q.grid_width;
        hdr_srow     = q.start_row;
        hdr_scol     = q.start_col;
        hdr_erow     = q.end_row;
        hdr_ecol     = q.end_col;
        hdr_limit    = q.step_limit;
      end
      CMD_BLOCK: begin
        // obstacles off the map are dropped
        if (on_map(q.cell_row, q.cell_col)) obstacle_map[cell_of(q.cell_row, q.cell_col)] = 1'b1;
      end
      CMD_RUN: begin
        expected_answers.push_back(search_target());
      end
      default: begin
        // unknown command: no state change, no answer
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // request builders: unused fields carry random bits so they get exercised
  // ---------------------------------------------------------------------------
  function automatic grid_request_t scrambled_request(logic [CMD_W-1:0] command);
    grid_request_t q;
    q.command     = command;
    q.grid_height = COORD_W'($urandom);
    q.grid_width  = COORD_W'($urandom);
    q.start_row   = COORD_W'($urandom);
    q.start_col   = COORD_W'($urandom);
    q.end_row     = COORD_W'($urandom);
    q.end_col     = COORD_W'($urandom);
    q.step_limit  = DIST_W'($urandom);
    q.cell_row    = COORD_W'($urandom);
    q.cell_col    = COORD_W'($urandom);
    return q;
  endfunction

  function automatic grid_request_t begin_request(int h, int w, int sr, int sc,
                                                  int er, int ec, int lim);
    grid_request_t q;
    q             = scrambled_request(CMD_BEGIN);
    q.grid_height = COORD_W'(h);
    q.grid_width  = COORD_W'(w);
    q.start_row   = COORD_W'(sr);
    q.start_col   = COORD_W'(sc);
    q.end_row     = COORD_W'(er);
    q.end_col     = COORD_W'(ec);
    q.step_limit  = DIST_W'(lim);
    return q;
  endfunction

  function automatic grid_request_t block_request(int r, int c);
    grid_request_t q;
    q          = scrambled_request(CMD_BLOCK);
    q.cell_row = COORD_W'(r);
    q.cell_col = COORD_W'(c);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: one request per call, held until the handshake completes
  // ---------------------------------------------------------------------------
  task automatic send_request(input grid_request_t q);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      // idle burst before this request
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i     <= q.command;
    grid_height_i <= q.grid_height;
    grid_width_i  <= q.grid_width;
    start_row_i   <= q.start_row;
    start_col_i   <= q.start_col;
    end_row_i     <= q.end_row;
    end_col_i     <= q.end_col;
    step_limit_i  <= q.step_limit;
    cell_row_i    <= q.cell_row;
    cell_col_i    <= q.cell_col;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop the request that was just taken, then wait for every answer
  task automatic wait_all_answered();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk_i);
  endtask

  // one query: a begin, then one to three searches with obstacles in between
  task automatic send_random_query(output int sent);
    int h, w, sr, sc, er, ec, lim, runs, blocks, r, c, i, j;
    sent = 0;
    // occasional unknown command as noise, not counted
    if ($urandom_range(0, 11) == 0) send_request(scrambled_request(CMD_UNUSED));
    h  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, DIM) : $urandom_range(1, 10);
    w  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, DIM) : $urandom_range(1, 10);
    sr = $urandom_range(1, h);
    sc = $urandom_range(1, w);
    er = $urandom_range(1, h);
    ec = $urandom_range(1, w);
    case ($urandom_range(0, 3))
      0:       lim = $urandom_range(0, 4);
      1:       lim = $urandom_range(0, 30);
      2:       lim = $urandom_range(0, 80);
      default: lim = $urandom_range(0, 1023);
    endcase
    // a few headers are fully random: oversize grids, off-map start or target
    if ($urandom_range(0, 15) == 0) send_request(scrambled_request(CMD_BEGIN));
    else send_request(begin_request(h, w, sr, sc, er, ec, lim));
    sent++;
    runs = $urandom_range(1, 3);
    for (j = 0; j < runs; j++) begin
      blocks = $urandom_range(0, ((h * w) / 4 > 6) ? 6 : (h * w) / 4);
      for (i = 0; i < blocks; i++) begin
        case ($urandom_range(0, 11))
          0:       begin r = sr; c = sc; end
          1:       begin r = er; c = ec; end
          2:       begin r = $urandom_range(0, 63); c = $urandom_range(0, 63); end
          default: begin r = $urandom_range(1, h); c = $urandom_range(1, w); end
        endcase
        send_request(block_request(r, c));
        sent++;
      end
      send_request(scrambled_request(CMD_RUN));
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_request--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: answers are checked before the request of the same edge is
  // applied, so ordering inside one edge never matters
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    reach_answer_t want;
    grid_request_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("answer with none pending: reachable %0b distance %0d",
                                  reachable_o, distance_o));
      end else begin
        want = expected_answers.pop_front();
        if (reachable_o !== want.reachable)
          report_mismatch($sformatf("reachable %0b, want %0b", reachable_o, want.reachable));
        if (distance_o !== want.distance)
          report_mismatch($sformatf("distance %0d, want %0d", distance_o, want.distance));
        if (want.reachable) reached_seen++;
        else unreached_seen++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      seen.command     = command_i;
      seen.grid_height = grid_height_i;
      seen.grid_width  = grid_width_i;
      seen.start_row   = start_row_i;
      seen.start_col   = start_col_i;
      seen.end_row     = end_row_i;
      seen.end_col     = end_col_i;
      seen.step_limit  = step_limit_i;
      seen.cell_row    = cell_row_i;
      seen.cell_col    = cell_col_i;
      apply_request(seen);
      requests_taken++;
      if (command_i == CMD_RUN) searches_taken++;
      if (command_i == CMD_UNUSED) ignored_taken++;
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked corners of the search
  task automatic test_directed_cases();
    // search right after reset: header is all zero, start lies off the map
    send_request(scrambled_request(CMD_RUN));
    // oversize grid saturates to the map, corner to corner at the widest limit
    send_request(begin_request(63, 63, 1, 1, DIM, DIM, 1023));
    // obstacles off the map are dropped
    send_request(block_request(0, 5));
    send_request(block_request(40, 63));
    send_request(scrambled_request(CMD_RUN));
    // wall with a gap forces a detour, then the gap closes
    send_request(begin_request(3, 3, 1, 1, 1, 3, 1023));
    send_request(block_request(1, 2));
    send_request(block_request(2, 2));
    send_request(scrambled_request(CMD_RUN));
    send_request(block_request(3, 2));
    send_request(scrambled_request(CMD_RUN));
    // blocked start is still expanded
    send_request(begin_request(4, 4, 2, 2, 2, 3, 1));
    send_request(block_request(2, 2));
    send_request(scrambled_request(CMD_RUN));
    // blocked start that is also the target is not reachable
    send_request(begin_request(4, 4, 2, 2, 2, 2, 0));
    send_request(block_request(2, 2));
    send_request(scrambled_request(CMD_RUN));
    // zero-size grid and zero limit: only the start itself counts
    send_request(begin_request(0, 0, 1, 1, 1, 1, 0));
    send_request(scrambled_request(CMD_RUN));
    // start below the grid but on the map steps back into the grid
    send_request(begin_request(3, 3, 4, 1, 3, 1, 5));
    send_request(scrambled_request(CMD_RUN));
    // start off the map, then target off the map
    send_request(begin_request(8, 8, 0, 1, 1, 1, 63));
    send_request(scrambled_request(CMD_RUN));
    send_request(begin_request(8, 8, 1, 1, 33, 1, 63));
    send_request(scrambled_request(CMD_RUN));
    // unknown command changes nothing
    send_request(scrambled_request(CMD_UNUSED));
    // limit one short of the full diagonal
    send_request(begin_request(DIM, DIM, DIM, DIM, 1, 1, 61));
    send_request(scrambled_request(CMD_RUN));
  endtask

  // well-formed queries with random content, some noise mixed in
  task automatic test_random_queries();
    int counted, sent;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // about one query in five runs with no idling at all
      idle_on = ($urandom_range(0, 4) != 0);
      send_random_query(sent);
      counted += sent;
    end
    idle_on = 1'b1;
  endtask

  // result side held off while searches keep coming: the block must stall its input
  task automatic test_output_backpressure();
    int i;
    idle_on = 1'b0;
    send_request(begin_request(6, 6, 1, 1, 6, 6, 20));
    hold_request = LONG_HOLD;
    send_request(block_request(3, 3));
    for (i = 0; i < 9; i++) send_request(scrambled_request(CMD_RUN));
    idle_on = 1'b1;
  endtask

  // request side waits for every pending answer before each query
  task automatic test_settle_between_queries();
    int i, sent;
    for (i = 0; i < 2; i++) begin
      wait_all_answered();
      send_random_query(sent);
    end
    wait_all_answered();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_quiet_finish();
    int counted, sent;
    idle_on = 1'b0;
    counted = 0;
    while (counted < QUIET_ITEMS) begin
      send_random_query(sent);
      counted += sent;
    end
  endtask

  initial begin : main_sequence
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_BEGIN;
    grid_height_i <= '0;
    grid_width_i  <= '0;
    start_row_i   <= '0;
    start_col_i   <= '0;
    end_row_i     <= '0;
    end_col_i     <= '0;
    step_limit_i  <= '0;
    cell_row_i    <= '0;
    cell_col_i    <= '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_queries();
    test_output_backpressure();
    test_settle_between_queries();
    test_quiet_finish();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain the pending answers, then leave room for a stray one
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d searches, %0d unknown commands",
             requests_taken, searches_taken, ignored_taken);
    $display("answers checked: %0d reachable, %0d not reachable, %0d mismatches",
             reached_seen, unreached_seen, error_count);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
